### rtl/sled_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sled_pkg;

    // pwm resolution of the drive stage
    localparam int unsigned PWM_BITS = 8;
    localparam logic [16:0] PWM_MAX  = 17'((64'd1 << PWM_BITS) - 64'd1);

    // config register fields
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LED_ENABLE     = 3'd0,
        REG_ACTIVE_LOW     = 3'd1,
        REG_BRIGHTNESS     = 3'd2,
        REG_CONNECT_PERIOD = 3'd3,
        REG_AP_PERIOD      = 3'd4,
        REG_ACTIVITY_HALF  = 3'd5,
        REG_ACTIVITY_HOLD  = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        MODE_OFF        = 3'd0,
        MODE_CONNECTING = 3'd1,
        MODE_WAITING    = 3'd2,
        MODE_CONNECTED  = 3'd3,
        MODE_AP         = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        CMD_OFF        = 3'd0,
        CMD_CONNECTING = 3'd1,
        CMD_WAITING    = 3'd2,
        CMD_CONNECTED  = 3'd3,
        CMD_AP         = 3'd4,
        CMD_PULSE      = 3'd5,
        CMD_REFRESH    = 3'd6
    } cmd_t;

    typedef enum logic {
        ACT_TICK    = 1'b0,
        ACT_COMMAND = 1'b1
    } action_t;

    typedef struct packed {
        logic       action;
        logic [2:0] command;
    } in_word_t;

    typedef struct packed {
        logic       led_lit;
        logic [7:0] pwm_duty;
        logic       pin_level;
        logic [7:0] pixel_level;
    } out_word_t;

endpackage

`default_nettype wire

### rtl/status_led_mode_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// status led controller: each input word is a one millisecond tick or a
// command, and every word gives exactly one result word with the lit state and
// all drive forms (pwm duty with polarity, digital pin level, pixel grey level).
// the mode, blink, activity and phase counters update at the edge that accepts
// the word, and the result is built from the updated state into an output
// register, so one word is taken every clock; the only stall is a full output
// register that the downstream side has not taken. m_valid is set at the edge
// that accepts the word. TIME_BITS sets the width of the three millisecond
// counters, which saturate at their all-ones value. config writes are always
// taken (cfg_ready is tied high) and should only be issued while idle.
module status_led_mode_controller
    import sled_pkg::*;
#(
    parameter int unsigned TIME_BITS = 16
) (
    input  wire                    aclk,
    input  wire                    aresetn,

    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire in_word_t          s_data,

    output logic                   m_valid,
    input  wire                    m_ready,
    output out_word_t              m_data,

    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire [CFG_INDEX_W-1:0]  cfg_index,
    input  wire [CFG_DATA_W-1:0]   cfg_data
);

    // compare width covers both the counters and the 16-bit thresholds
    localparam int unsigned CW = (TIME_BITS > CFG_DATA_W) ? TIME_BITS : CFG_DATA_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // config registers
    logic                  led_enable_reg;
    logic                  active_low_reg;
    logic [7:0]            brightness_reg;
    logic [CFG_DATA_W-1:0] connect_period_reg;
    logic [CFG_DATA_W-1:0] ap_period_reg;
    logic [CFG_DATA_W-1:0] activity_half_reg;
    logic [CFG_DATA_W-1:0] activity_hold_reg;

    // controller state
    mode_t                 mode_reg, mode_next;
    logic                  blink_on_reg, blink_on_next;
    logic [TIME_BITS-1:0]  blink_count_reg, blink_count_next;
    logic                  act_valid_reg, act_valid_next;
    logic [TIME_BITS-1:0]  act_elapsed_reg, act_elapsed_next;
    logic [TIME_BITS-1:0]  phase_count_reg, phase_count_next;
    logic                  phase_bit_reg, phase_bit_next;

    // output register
    logic                  m_valid_reg;
    out_word_t             m_data_reg, m_data_next;

    logic                  s_fire;
    logic [TIME_BITS-1:0]  phase_inc, blink_inc, act_inc;
    logic [CFG_DATA_W-1:0] period;
    logic                  recent;
    logic                  lit;
    logic [7:0]            on_level;

    assign cfg_ready = 1'b1;

    // output register frees up when its word is taken
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // config write port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_enable_reg     <= 1'b1;
            active_low_reg     <= 1'b0;
            brightness_reg     <= 8'd255;
            connect_period_reg <= 16'd350;
            ap_period_reg      <= 16'd120;
            activity_half_reg  <= 16'd25;
            activity_hold_reg  <= 16'd120;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_LED_ENABLE:     led_enable_reg     <= cfg_data[0];
                REG_ACTIVE_LOW:     active_low_reg     <= cfg_data[0];
                REG_BRIGHTNESS:     brightness_reg     <= cfg_data[7:0];
                REG_CONNECT_PERIOD: connect_period_reg <= cfg_data;
                REG_AP_PERIOD:      ap_period_reg      <= cfg_data;
                REG_ACTIVITY_HALF:  activity_half_reg  <= cfg_data;
                REG_ACTIVITY_HOLD:  activity_hold_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // saturating increments
    assign phase_inc = (phase_count_reg == TIME_MAX) ? TIME_MAX : phase_count_reg + 1'b1;
    assign blink_inc = (blink_count_reg == TIME_MAX) ? TIME_MAX : blink_count_reg + 1'b1;
    assign act_inc   = (act_elapsed_reg == TIME_MAX) ? TIME_MAX : act_elapsed_reg + 1'b1;
    assign period    = (mode_reg == MODE_AP) ? ap_period_reg : connect_period_reg;

    // next state for one word
    always_comb begin
        mode_next        = mode_reg;
        blink_on_next    = blink_on_reg;
        blink_count_next = blink_count_reg;
        act_valid_next   = act_valid_reg;
        act_elapsed_next = act_elapsed_reg;
        phase_count_next = phase_count_reg;
        phase_bit_next   = phase_bit_reg;

        if (s_data.action == ACT_TICK) begin
            // free-running phase for the activity blink
            if (CW'(phase_inc) >= CW'(activity_half_reg)) begin
                phase_count_next = '0;
                phase_bit_next   = !phase_bit_reg;
            end else begin
                phase_count_next = phase_inc;
            end
            // blink timing only in the blinking modes
            if (mode_reg == MODE_CONNECTING || mode_reg == MODE_AP) begin
                if (CW'(blink_inc) >= CW'(period)) begin
                    blink_count_next = '0;
                    blink_on_next    = !blink_on_reg;
                end else begin
                    blink_count_next = blink_inc;
                end
            end
            // activity hold window
            if (act_valid_reg) begin
                act_elapsed_next = act_inc;
                if (CW'(act_inc) >= CW'(activity_hold_reg)) begin
                    act_valid_next = 1'b0;
                end
            end
        end else begin
            // any command restarts the blink wait
            blink_count_next = '0;
            case (cmd_t'(s_data.command))
                CMD_OFF, CMD_CONNECTING, CMD_WAITING, CMD_CONNECTED, CMD_AP: begin
                    mode_next        = mode_t'(s_data.command);
                    blink_on_next    = 1'b0;
                    act_valid_next   = 1'b0;
                    act_elapsed_next = '0;
                end
                CMD_PULSE: begin
                    // pulse only counts while a client is connected
                    if (mode_reg == MODE_CONNECTED) begin
                        act_valid_next   = 1'b1;
                        act_elapsed_next = '0;
                    end
                end
                default: ;  // refresh and unused code: only the blink wait restarts
            endcase
        end
    end

    // result built from the updated state
    always_comb begin
        recent = act_valid_next && (CW'(act_elapsed_next) < CW'(activity_hold_reg));

        case (mode_next)
            MODE_CONNECTING, MODE_AP: lit = blink_on_next;
            MODE_CONNECTED:           lit = recent ? phase_bit_next : 1'b1;
            default:                  lit = 1'b0;
        endcase
        lit = lit && led_enable_reg;

        // clamp brightness to the pwm range
        on_level = ({9'd0, brightness_reg} > PWM_MAX) ? PWM_MAX[7:0] : brightness_reg;

        m_data_next.led_lit = lit;
        if (active_low_reg) begin
            m_data_next.pwm_duty = lit ? (PWM_MAX[7:0] - on_level) : PWM_MAX[7:0];
        end else begin
            m_data_next.pwm_duty = lit ? on_level : 8'd0;
        end
        if (lit && (on_level != 8'd0)) begin
            m_data_next.pin_level = !active_low_reg;
        end else begin
            m_data_next.pin_level = active_low_reg;
        end
        m_data_next.pixel_level = lit ? on_level : 8'd0;
    end

    // state registers advance on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_OFF;
            blink_on_reg    <= 1'b0;
            blink_count_reg <= '0;
            act_valid_reg   <= 1'b0;
            act_elapsed_reg <= '0;
            phase_count_reg <= '0;
            phase_bit_reg   <= 1'b0;
        end else if (s_fire) begin
            mode_reg        <= mode_next;
            blink_on_reg    <= blink_on_next;
            blink_count_reg <= blink_count_next;
            act_valid_reg   <= act_valid_next;
            act_elapsed_reg <= act_elapsed_next;
            phase_count_reg <= phase_count_next;
            phase_bit_reg   <= phase_bit_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

`default_nettype wire
